FILE: rtl/sth_pkg.sv
// Shared constants for the segment/triangle hit pipeline.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package sth_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FIELD_W        = 48;
  localparam int unsigned LIMB_W         = 24;
  localparam int unsigned NUM_VEC        = 7;
  localparam int unsigned NUM_CROSS      = 8;

  localparam int unsigned V_E0  = 0;
  localparam int unsigned V_E1  = 1;
  localparam int unsigned V_E2  = 2;
  localparam int unsigned V_DIR = 3;
  localparam int unsigned V_B0  = 4;
  localparam int unsigned V_B1  = 5;
  localparam int unsigned V_TA  = 6;

  localparam int unsigned X_N    = 0;
  localparam int unsigned X_ADEL = 1;
  localparam int unsigned X_F1Q  = 2;
  localparam int unsigned X_G1P  = 3;
  localparam int unsigned X_G1Q  = 4;
  localparam int unsigned X_F2Q  = 5;
  localparam int unsigned X_G2P  = 6;
  localparam int unsigned X_G2Q  = 7;
endpackage

FILE: rtl/sth_if.sv
// Valid/ready channel interfaces for the hit pipeline.
// Depends on sth_pkg for the field width.
`timescale 1ns / 1ps
interface sth_in_if import sth_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] vertex_a;
  logic [FIELD_W-1:0] vertex_b;
  logic [FIELD_W-1:0] vertex_c;
  logic [FIELD_W-1:0] seg_start;
  logic [FIELD_W-1:0] seg_stop;
  modport source(output valid, vertex_a, vertex_b, vertex_c, seg_start, seg_stop,
                 input ready);
  modport sink(input valid, vertex_a, vertex_b, vertex_c, seg_start, seg_stop,
               output ready);
endinterface

interface sth_out_if ();
  logic valid;
  logic ready;
  logic hit;
  modport source(output valid, hit, input ready);
  modport sink(input valid, hit, output ready);
endinterface

FILE: rtl/sth_mul.sv
// Two-stage signed multiplier built from limb partial products.
// Depends on sth_pkg for the limb width.
`timescale 1ns / 1ps
module sth_mul import sth_pkg::*; #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32,
  localparam int unsigned WP = WA + WB
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WP-1:0] p
);
  localparam int unsigned NA = (WA + LIMB_W - 1) / LIMB_W;
  localparam int unsigned NB = (WB + LIMB_W - 1) / LIMB_W;
  localparam int unsigned PPW = 2 * LIMB_W + 2;

  logic signed [NA*LIMB_W-1:0] ae;
  logic signed [NB*LIMB_W-1:0] be;
  logic signed [LIMB_W:0]      al [NA];
  logic signed [LIMB_W:0]      bl [NB];
  logic signed [PPW-1:0]       pp_r [NA*NB];
  logic signed [WP-1:0]        acc;
  logic signed [WP-1:0]        p_r;

  always_comb begin
    ae = (NA*LIMB_W)'(a);
    be = (NB*LIMB_W)'(b);
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        al[i] = {ae[i*LIMB_W+LIMB_W-1], ae[i*LIMB_W +: LIMB_W]};
      end else begin
        al[i] = {1'b0, ae[i*LIMB_W +: LIMB_W]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        bl[j] = {be[j*LIMB_W+LIMB_W-1], be[j*LIMB_W +: LIMB_W]};
      end else begin
        bl[j] = {1'b0, be[j*LIMB_W +: LIMB_W]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= PPW'(al[i]) * PPW'(bl[j]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (WP'(pp_r[i*NB+j]) <<< ((i + j) * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc;
    end
  end

  assign p = p_r;
endmodule

FILE: rtl/sth_front.sv
// Front end: coordinate differences and the eight cross products.
// Depends on sth_pkg; three register stages.
`timescale 1ns / 1ps
module sth_front import sth_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned W1 = COORD_BITS + 1,
  localparam int unsigned W3 = 2 * COORD_BITS + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [FIELD_W-1:0]   vertex_a,
  input  logic [FIELD_W-1:0]   vertex_b,
  input  logic [FIELD_W-1:0]   vertex_c,
  input  logic [FIELD_W-1:0]   seg_start,
  input  logic [FIELD_W-1:0]   seg_stop,
  output logic                 valid3,
  output logic signed [W3-1:0] xprod [NUM_CROSS][3],
  output logic signed [W1-1:0] b0 [3],
  output logic signed [W1-1:0] ta [3]
);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned WP = 2 * COORD_BITS + 2;
  localparam int unsigned EW = FIELD_W + 3 * COORD_BITS;
  localparam int unsigned XA [NUM_CROSS] =
    '{V_E0, V_E0, V_E0, V_DIR, V_B0, V_E0, V_DIR, V_B1};
  localparam int unsigned XB [NUM_CROSS] =
    '{V_E1, V_DIR, V_B0, V_E1, V_E1, V_B1, V_E2, V_E2};

  logic [EW-1:0]         ea, eb, ec, es, et;
  logic signed [C-1:0]   la [3], lb [3], lc [3], ls [3], lt [3];
  logic signed [W1-1:0]  vec_nxt [NUM_VEC][3];
  logic signed [W1-1:0]  vec_r [NUM_VEC][3];
  logic signed [WP-1:0]  pa_r [NUM_CROSS][3];
  logic signed [WP-1:0]  pb_r [NUM_CROSS][3];
  logic signed [W1-1:0]  b0_2_r [3], ta_2_r [3], b0_3_r [3], ta_3_r [3];
  logic signed [W3-1:0]  cross_r [NUM_CROSS][3];
  logic                  v1_r, v2_r, v3_r;

  assign ea = EW'(vertex_a);
  assign eb = EW'(vertex_b);
  assign ec = EW'(vertex_c);
  assign es = EW'(seg_start);
  assign et = EW'(seg_stop);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      la[k] = ea[k*C +: C];
      lb[k] = eb[k*C +: C];
      lc[k] = ec[k*C +: C];
      ls[k] = es[k*C +: C];
      lt[k] = et[k*C +: C];
      vec_nxt[V_E0][k]  = W1'(lb[k]) - W1'(la[k]);
      vec_nxt[V_E1][k]  = W1'(lc[k]) - W1'(la[k]);
      vec_nxt[V_E2][k]  = W1'(lb[k]) - W1'(lc[k]);
      vec_nxt[V_DIR][k] = W1'(lt[k]) - W1'(ls[k]);
      vec_nxt[V_B0][k]  = W1'(ls[k]) - W1'(la[k]);
      vec_nxt[V_B1][k]  = W1'(ls[k]) - W1'(lb[k]);
      vec_nxt[V_TA][k]  = W1'(lt[k]) - W1'(la[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
      for (int x = 0; x < NUM_CROSS; x++) begin
        for (int k = 0; k < 3; k++) begin
          pa_r[x][k] <= WP'(vec_r[XA[x]][(k+1)%3]) * WP'(vec_r[XB[x]][(k+2)%3]);
          pb_r[x][k] <= WP'(vec_r[XA[x]][(k+2)%3]) * WP'(vec_r[XB[x]][(k+1)%3]);
          cross_r[x][k] <= W3'(pa_r[x][k]) - W3'(pb_r[x][k]);
        end
      end
      b0_2_r <= vec_r[V_B0];
      ta_2_r <= vec_r[V_TA];
      b0_3_r <= b0_2_r;
      ta_3_r <= ta_2_r;
    end
  end

  assign valid3 = v3_r;
  assign xprod  = cross_r;
  assign b0     = b0_3_r;
  assign ta     = ta_3_r;
endmodule

FILE: rtl/segment_triangle_hit_projected_top.sv
// Segment/triangle hit pipeline, top level.
// Depends on sth_pkg, sth_if, sth_front and sth_mul.
//
// Accepts one triangle/segment transaction every clock cycle unless stalled,
// and delivers its hit bit through three front-end stages for differences and
// cross products, two for the plane products, two for the plane sums and axis
// choice, two for the wide edge-test products, one for the final sums and one
// output register. Every multiply above the limb width is split into limb
// products. The whole pipeline holds while a finished result is not taken.
`timescale 1ns / 1ps
module segment_triangle_hit_projected_top import sth_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sth_in_if.sink      in_ch,
  sth_out_if.source   out_ch
);
  localparam int unsigned W1  = COORD_BITS + 1;
  localparam int unsigned W3  = 2 * COORD_BITS + 3;
  localparam int unsigned WNB = W3 + W1;
  localparam int unsigned WNN = 2 * W3;
  localparam int unsigned WS  = 3 * COORD_BITS + 6;
  localparam int unsigned WD  = 3 * COORD_BITS + 7;
  localparam int unsigned WQ  = 4 * COORD_BITS + 9;
  localparam int unsigned WM  = WD + W3;
  localparam int unsigned WF  = WM + 1;
  localparam int unsigned NSEL = NUM_CROSS - 1;

  logic                  en;
  logic                  v3, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic                  rej6_r, rej7_r, rej8_r, rej9_r, rej10_r;
  logic signed [W3-1:0]  cross3 [NUM_CROSS][3];
  logic signed [W3-1:0]  cross4_r [NUM_CROSS][3], cross5_r [NUM_CROSS][3];
  logic signed [W1-1:0]  b0_3 [3], ta_3 [3];
  logic signed [WNB-1:0] nb [3], nt [3];
  logic signed [WNN-1:0] nn [3];
  logic signed [WS-1:0]  ss_c, se_c, ss6_r, se6_r;
  logic signed [WQ-1:0]  q_c, d0_c, d1_c;
  logic [1:0]            ax_c;
  logic                  rej_c;
  logic signed [W3-1:0]  sel6_r [NSEL], sel7_r [NSEL];
  logic signed [WD-1:0]  ss7_r, dd7_r;
  logic signed [WM-1:0]  m [NSEL];
  logic signed [WF-1:0]  fg10_r [4];
  logic                  out_valid_r, out_hit_r;

  function automatic logic agree(input logic signed [WF-1:0] f,
                                 input logic signed [WF-1:0] g);
    agree = (f != '0) && (g != '0) && (f[WF-1] == g[WF-1]);
  endfunction

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  sth_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
    .vertex_a(in_ch.vertex_a), .vertex_b(in_ch.vertex_b),
    .vertex_c(in_ch.vertex_c), .seg_start(in_ch.seg_start),
    .seg_stop(in_ch.seg_stop), .valid3(v3), .xprod(cross3),
    .b0(b0_3), .ta(ta_3)
  );

  for (genvar k = 0; k < 3; k++) begin : g_plane
    sth_mul #(.WA(W3), .WB(W1)) u_nb (
      .clk(clk), .en(en), .a(cross3[X_N][k]), .b(b0_3[k]), .p(nb[k]));
    sth_mul #(.WA(W3), .WB(W1)) u_nt (
      .clk(clk), .en(en), .a(cross3[X_N][k]), .b(ta_3[k]), .p(nt[k]));
    sth_mul #(.WA(W3), .WB(W3)) u_nn (
      .clk(clk), .en(en), .a(cross3[X_N][k]), .b(cross3[X_N][k]), .p(nn[k]));
  end

  always_comb begin
    ss_c = WS'(nb[0]) + WS'(nb[1]) + WS'(nb[2]);
    se_c = WS'(nt[0]) + WS'(nt[1]) + WS'(nt[2]);
    q_c  = WQ'(nn[0]) + WQ'(nn[1]) + WQ'(nn[2]);
    d0_c = (WQ'(nn[0]) <<< 1) + WQ'(nn[0]) - q_c;
    d1_c = (WQ'(nn[1]) <<< 1) + WQ'(nn[1]) - q_c;
    if (!d0_c[WQ-1] && d0_c != '0) begin
      ax_c = 2'd0;
    end else if (!d1_c[WQ-1] && d1_c != '0) begin
      ax_c = 2'd1;
    end else begin
      ax_c = 2'd2;
    end
    rej_c = (ss_c != '0) && (se_c != '0) && (ss_c[WS-1] == se_c[WS-1]);
  end

  for (genvar j = 0; j < NSEL; j++) begin : g_edge
    sth_mul #(.WA(WD), .WB(W3)) u_m (
      .clk(clk), .en(en), .a((j == X_ADEL - 1 || j == X_G1P - 1 || j == X_G2P - 1)
                             ? ss7_r : dd7_r),
      .b(sel7_r[j]), .p(m[j]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
      v8_r <= 1'b0; v9_r <= 1'b0; v10_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3; v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
      v8_r <= v7_r; v9_r <= v8_r; v10_r <= v9_r;
      out_valid_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cross4_r <= cross3;
      cross5_r <= cross4_r;
      ss6_r  <= ss_c;
      se6_r  <= se_c;
      rej6_r <= rej_c;
      for (int j = 0; j < NSEL; j++) begin
        sel6_r[j] <= cross5_r[j+1][ax_c];
      end
      ss7_r  <= WD'(ss6_r);
      dd7_r  <= WD'(ss6_r) - WD'(se6_r);
      sel7_r <= sel6_r;
      rej7_r <= rej6_r;
      rej8_r <= rej7_r;
      rej9_r <= rej8_r;
      fg10_r[0] <= WF'(m[X_ADEL-1]) + WF'(m[X_F1Q-1]);
      fg10_r[1] <= WF'(m[X_G1P-1])  + WF'(m[X_G1Q-1]);
      fg10_r[2] <= WF'(m[X_ADEL-1]) + WF'(m[X_F2Q-1]);
      fg10_r[3] <= WF'(m[X_G2P-1])  + WF'(m[X_G2Q-1]);
      rej10_r <= rej9_r;
      out_hit_r <= !rej10_r && agree(fg10_r[0], fg10_r[1])
                   && agree(fg10_r[2], fg10_r[3]);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;
endmodule
